// ===== rtl/core/pwcsb_pkg.sv =====
// Shared types and constants for the PWM channel bank with sensor block.
package pwcsb_pkg;

  // Channel bank size and field widths
  localparam int unsigned CHANNELS = 9;
  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PIN_W    = 9;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam logic [CH_W-1:0]  LAST_CH = CH_W'(CHANNELS - 1);

  // Reset values
  localparam logic [LEN_W-1:0] DEFAULT_OFF_LEN = 32'd10000;
  localparam logic [CNT_W-1:0] DEFAULT_COUNT   = 16'd20000;
  localparam logic [PIN_W-1:0] DEFAULT_MASK    = 9'd3;
  localparam logic [CNT_W-1:0] CNT_ONE         = 16'd1;

  // Set-request index decoding: indices above OFF_IDX_LIMIT write only an
  // off length; OFF_IDX_BASE and the next index address channels 0 and 1
  localparam logic [IDX_W-1:0] OFF_IDX_LIMIT = 4'd9;
  localparam logic [IDX_W-1:0] OFF_IDX_BASE  = 4'd10;
  localparam logic [IDX_W-1:0] OFF_CH_LAST   = 4'd1;
  localparam logic [IDX_W-1:0] SHARED_CH_MIN = 4'd2;

  // Request codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BLOCK_MASK = 2'd0,
    REG_THRESHOLD  = 2'd1,
    REG_RELEASE    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic             cmd;
    logic             sensor_hit;
    logic [IDX_W-1:0] ch_index;
    logic [LEN_W-1:0] value;
  } pwcsb_in_t;

  typedef struct packed {
    logic [PIN_W-1:0] pin_levels;
    logic             blocked;
    logic             alarm;
  } pwcsb_out_t;

  typedef struct packed {
    logic [PIN_W-1:0] blockable_mask;
    logic [CNT_W-1:0] block_threshold;
    logic [CNT_W-1:0] release_count;
  } pwcsb_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic            load_in;
    logic            do_block;
    logic            do_step;
    logic            do_set;
    logic            load_out;
    logic [CH_W-1:0] ch_idx;
  } pwcsb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_set;
  } pwcsb_status_t;

endpackage

// ===== rtl/core/pwcsb_regs.sv =====
// Configuration register file behind the APB-style port.
module pwcsb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwcsb_pkg::ADDR_W-1:0]  paddr,
  input  logic [pwcsb_pkg::DATA_W-1:0]  pwdata,
  output logic [pwcsb_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output pwcsb_pkg::pwcsb_cfg_t         cfg_o
);
  import pwcsb_pkg::*;

  pwcsb_cfg_t cfg_q;
  logic       wr_en;
  reg_idx_e   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blockable_mask  <= DEFAULT_MASK;
      cfg_q.block_threshold <= DEFAULT_COUNT;
      cfg_q.release_count   <= DEFAULT_COUNT;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BLOCK_MASK: cfg_q.blockable_mask  <= pwdata[PIN_W-1:0];
        REG_THRESHOLD:  cfg_q.block_threshold <= pwdata[CNT_W-1:0];
        REG_RELEASE:    cfg_q.release_count   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_MASK: prdata = DATA_W'(cfg_q.blockable_mask);
      REG_THRESHOLD:  prdata = DATA_W'(cfg_q.block_threshold);
      REG_RELEASE:    prdata = DATA_W'(cfg_q.release_count);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/pwcsb_dp.sv =====
// Datapath: channel state, block hysteresis counter and result register.
module pwcsb_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pwcsb_pkg::pwcsb_cfg_t    cfg_i,
  input  pwcsb_pkg::pwcsb_cmd_t    cmd_i,
  input  pwcsb_pkg::pwcsb_in_t     in_data_i,
  output pwcsb_pkg::pwcsb_status_t status_o,
  output pwcsb_pkg::pwcsb_out_t    out_data_o
);
  import pwcsb_pkg::*;

  pwcsb_in_t            item_q;
  pwcsb_out_t           out_q;
  logic [LEN_W-1:0]     on_len_q  [CHANNELS];
  logic [LEN_W-1:0]     off_len_q [CHANNELS];
  logic [LEN_W-1:0]     phase_q   [CHANNELS];
  logic [CHANNELS-1:0]  pin_q;
  logic [CNT_W-1:0]     blk_cnt_q, blk_cnt_d;
  logic                 active_q, active_d;
  logic                 alarm_q, alarm_d;

  logic [CNT_W-1:0]     cnt_inc, cnt_dec;
  logic [CHANNELS-1:0]  blk_vec;
  logic [PIN_W-1:0]     pin_vec;

  logic [LEN_W-1:0]     cur_on, cur_off, cur_ph, ph_ld, step_ph;
  logic                 cur_pin, step_pin;

  logic                 off_only, set_ok, wr_on, wr_off, clear_pin;
  logic [IDX_W-1:0]     set_ch;
  logic [CH_W-1:0]      set_sel;
  logic [LEN_W-1:0]     new_on;

  // Map the mask onto the bank; channels past the mask width never block
  for (genvar i = 0; i < CHANNELS; i++) begin : g_blk
    if (i < PIN_W) begin : g_in
      assign blk_vec[i] = cfg_i.blockable_mask[i];
    end else begin : g_out
      assign blk_vec[i] = 1'b0;
    end
  end

  // Gather pin levels for the result
  for (genvar i = 0; i < PIN_W; i++) begin : g_pin
    if (i < CHANNELS) begin : g_in
      assign pin_vec[i] = pin_q[i];
    end else begin : g_out
      assign pin_vec[i] = 1'b0;
    end
  end

  // Advance the block hysteresis counter from the sensor level
  always_comb begin
    cnt_inc   = (blk_cnt_q != '1) ? blk_cnt_q + CNT_ONE : blk_cnt_q;
    cnt_dec   = (blk_cnt_q != '0) ? blk_cnt_q - CNT_ONE : blk_cnt_q;
    blk_cnt_d = blk_cnt_q;
    active_d  = active_q;
    alarm_d   = alarm_q;
    if (active_q) begin
      if (item_q.sensor_hit) begin
        blk_cnt_d = cfg_i.release_count;
      end else if (cnt_dec <= CNT_ONE) begin
        active_d  = 1'b0;
        blk_cnt_d = CNT_ONE;
      end else begin
        blk_cnt_d = cnt_dec;
      end
    end else if (item_q.sensor_hit) begin
      if (cnt_inc >= cfg_i.block_threshold) begin
        active_d  = 1'b1;
        alarm_d   = 1'b1;
        blk_cnt_d = cfg_i.release_count;
      end else begin
        blk_cnt_d = cnt_inc;
      end
    end else begin
      blk_cnt_d = CNT_ONE;
    end
  end

  // Step the selected channel: force low, or toggle and reload, then count down
  always_comb begin
    cur_on   = on_len_q[cmd_i.ch_idx];
    cur_off  = off_len_q[cmd_i.ch_idx];
    cur_ph   = phase_q[cmd_i.ch_idx];
    cur_pin  = pin_q[cmd_i.ch_idx];
    ph_ld    = cur_ph;
    step_ph  = cur_ph;
    step_pin = cur_pin;
    if (cur_on != '0) begin
      if (blk_vec[cmd_i.ch_idx] && active_q) begin
        step_pin = 1'b0;
      end else begin
        if (cur_ph == '0) begin
          step_pin = !cur_pin;
          ph_ld    = cur_pin ? cur_off : cur_on;
        end
        step_ph = (ph_ld != '0) ? ph_ld - LEN_W'(1) : ph_ld;
      end
    end
  end

  // Decode a set request
  always_comb begin
    off_only  = item_q.ch_index > OFF_IDX_LIMIT;
    set_ch    = off_only ? item_q.ch_index - OFF_IDX_BASE : item_q.ch_index;
    set_ok    = off_only ? (set_ch <= OFF_CH_LAST)
                         : ({1'b0, set_ch} < (IDX_W + 1)'(CHANNELS));
    set_sel   = set_ch[CH_W-1:0];
    wr_on     = set_ok && !off_only;
    wr_off    = set_ok && (off_only || set_ch >= SHARED_CH_MIN);
    new_on    = wr_on ? item_q.value : on_len_q[set_sel];
    clear_pin = set_ok && (new_on == '0);
  end

  // Hold channel and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        on_len_q[i]  <= '0;
        off_len_q[i] <= (i < 2) ? DEFAULT_OFF_LEN : '0;
        phase_q[i]   <= '0;
      end
      pin_q     <= '0;
      blk_cnt_q <= '0;
      active_q  <= 1'b0;
      alarm_q   <= 1'b0;
    end else begin
      if (cmd_i.do_block) begin
        blk_cnt_q <= blk_cnt_d;
        active_q  <= active_d;
        alarm_q   <= alarm_d;
      end
      if (cmd_i.do_step) begin
        phase_q[cmd_i.ch_idx] <= step_ph;
        pin_q[cmd_i.ch_idx]   <= step_pin;
      end
      if (cmd_i.do_set) begin
        if (wr_on) begin
          on_len_q[set_sel] <= item_q.value;
        end
        if (wr_off) begin
          off_len_q[set_sel] <= item_q.value;
        end
        if (clear_pin) begin
          pin_q[set_sel] <= 1'b0;
        end
      end
    end
  end

  // Capture the request and the finished result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= in_data_i;
    end
    if (cmd_i.load_out) begin
      out_q.pin_levels <= pin_vec;
      out_q.blocked    <= active_q;
      out_q.alarm      <= alarm_q;
    end
  end

  assign status_o.is_set = (item_q.cmd == CMD_SET);
  assign out_data_o      = out_q;

endmodule

// ===== rtl/core/pwcsb_ctrl.sv =====
// Controller: sequences one request through block update, channel walk and result, or through set and result.
module pwcsb_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  pwcsb_pkg::pwcsb_status_t status_i,
  output pwcsb_pkg::pwcsb_cmd_t    cmd_o
);
  import pwcsb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [CH_W-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;

  // Sequence the request and issue datapath commands
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.ch_idx = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_set) begin
          cmd_o.do_set = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.do_block = 1'b1;
          idx_d          = '0;
          state_d        = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.do_step = 1'b1;
        if (idx_q == LAST_CH) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + CH_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state, walk index and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/pwm_channels_with_sensor_block.sv =====
// Top level of the PWM channel bank with sensor-blocking hysteresis.
// One request is worked at a time. A tick request first updates the block
// counter, then steps each channel in turn through a single shared update
// unit, then loads the result register, then returns to idle, where the next
// request is accepted. A set request applies the set, loads the result and
// returns to idle to accept the next. The result sits in an output register,
// so a new request is taken while it waits; only when an older result is
// still stalled at the output does the block hold in its load cycle until
// that result is taken. The alarm output is sticky until reset.
// Configuration writes are taken at any time and should only be made while
// no request is in flight.
module pwm_channels_with_sensor_block (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pwcsb_pkg::pwcsb_in_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pwcsb_pkg::pwcsb_out_t         out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwcsb_pkg::ADDR_W-1:0]  paddr,
  input  logic [pwcsb_pkg::DATA_W-1:0]  pwdata,
  output logic [pwcsb_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import pwcsb_pkg::*;

  pwcsb_cfg_t    cfg;
  pwcsb_cmd_t    cmd;
  pwcsb_status_t status;

  pwcsb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwcsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pwcsb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // A blocked result always carries the alarm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.blocked || out_data_o.alarm))
    else $error("blocked result without alarm");

  // Only one request in flight: stall right after an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in work");

  // A new result appears only at the end of a request in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in work");
`endif

endmodule

// ===== tb/sv/tb_pwm_channels_with_sensor_block.sv =====
// Self-checking testbench for the PWM channel bank with sensor-blocking hysteresis.
`timescale 1ns / 1ps

module tb_pwm_channels_with_sensor_block;
  import pwcsb_pkg::*;

  // Set-request decoding as the bank sees it: indices from here on write only
  // an off length; the first two reach channels 0 and 1, the rest are dropped
  localparam int FIRST_OFF_INDEX = 10;
  localparam int LAST_OFF_CHANNEL = 1;
  localparam int FIRST_SHARED_CHANNEL = 2;

  // Mirror of the channel bank; holds the expected outputs in request order
  class pwm_bank_scoreboard;
    logic [PIN_W-1:0] blk_mask;
    logic [CNT_W-1:0] blk_threshold;
    logic [CNT_W-1:0] rel_count;
    logic [LEN_W-1:0] on_len [CHANNELS];
    logic [LEN_W-1:0] off_len [CHANNELS];
    logic [LEN_W-1:0] phase_cnt [CHANNELS];
    logic             pin_lvl [CHANNELS];
    logic [CNT_W-1:0] blk_cnt;
    logic             blk_active;
    logic             alarm_flag;
    pwcsb_out_t       pending_levels [$];
    int               errors;

    function new();
      blk_mask      = DEFAULT_MASK;
      blk_threshold = 16'd20000;
      rel_count     = 16'd20000;
      for (int i = 0; i < CHANNELS; i++) begin
        on_len[i]    = '0;
        off_len[i]   = (i < 2) ? 32'd10000 : 32'd0;
        phase_cnt[i] = '0;
        pin_lvl[i]   = 1'b0;
      end
      blk_cnt    = '0;
      blk_active = 1'b0;
      alarm_flag = 1'b0;
      errors     = 0;
    endfunction

    function void set_cfg(reg_idx_e idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_BLOCK_MASK: blk_mask = data[PIN_W-1:0];
        REG_THRESHOLD:  blk_threshold = data[CNT_W-1:0];
        REG_RELEASE:    rel_count = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the hysteresis counter by one tick
    function void update_block(logic sensed);
      if (blk_active) begin
        if (sensed) begin
          blk_cnt = rel_count;
        end else begin
          if (blk_cnt != '0) blk_cnt = blk_cnt - 1'b1;
          if (blk_cnt <= 16'd1) begin
            blk_active = 1'b0;
            blk_cnt    = 16'd1;
          end
        end
      end else if (sensed) begin
        if (blk_cnt != '1) blk_cnt = blk_cnt + 1'b1;
        if (blk_cnt >= blk_threshold) begin
          blk_active = 1'b1;
          alarm_flag = 1'b1;
          blk_cnt    = rel_count;
        end
      end else begin
        blk_cnt = 16'd1;
      end
    endfunction

    // Step every enabled channel once
    function void step_channels();
      for (int i = 0; i < CHANNELS; i++) begin
        if (on_len[i] != '0) begin
          if (i < PIN_W && blk_mask[i] && blk_active) begin
            pin_lvl[i] = 1'b0;
          end else begin
            if (phase_cnt[i] == '0) begin
              if (pin_lvl[i]) begin
                pin_lvl[i]   = 1'b0;
                phase_cnt[i] = off_len[i];
              end else begin
                pin_lvl[i]   = 1'b1;
                phase_cnt[i] = on_len[i];
              end
            end
            if (phase_cnt[i] != '0) phase_cnt[i] = phase_cnt[i] - 1'b1;
          end
        end
      end
    endfunction

    function void apply_set(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] val);
      int  ch;
      bit  off_only;
      ch       = int'(idx);
      off_only = 1'b0;
      if (ch >= FIRST_OFF_INDEX) begin
        ch       = ch - FIRST_OFF_INDEX;
        off_only = 1'b1;
        if (ch > LAST_OFF_CHANNEL) return;
      end
      if (ch >= CHANNELS) return;
      if (ch < FIRST_SHARED_CHANNEL) begin
        if (off_only) off_len[ch] = val;
        else on_len[ch] = val;
      end else begin
        on_len[ch]  = val;
        off_len[ch] = val;
      end
      if (on_len[ch] == '0) pin_lvl[ch] = 1'b0;
    endfunction

    // Apply an accepted request and queue the outputs it should produce
    function void note_request(pwcsb_in_t req);
      pwcsb_out_t want;
      if (req.cmd == CMD_TICK) begin
        update_block(req.sensor_hit);
        step_channels();
      end else begin
        apply_set(req.ch_index, req.value);
      end
      want.pin_levels = '0;
      for (int i = 0; i < CHANNELS && i < PIN_W; i++) want.pin_levels[i] = pin_lvl[i];
      want.blocked = blk_active;
      want.alarm   = alarm_flag;
      pending_levels.push_back(want);
    endfunction

    function int outstanding();
      return pending_levels.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(pwcsb_out_t got);
      pwcsb_out_t want;
      if (pending_levels.size() == 0) begin
        report("result arrived with no request outstanding");
      end else begin
        want = pending_levels.pop_front();
        if (got.pin_levels !== want.pin_levels)
          report($sformatf("pin_levels got %03h want %03h", got.pin_levels, want.pin_levels));
        if (got.blocked !== want.blocked)
          report($sformatf("blocked got %b want %b", got.blocked, want.blocked));
        if (got.alarm !== want.alarm)
          report($sformatf("alarm got %b want %b", got.alarm, want.alarm));
      end
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  pwcsb_in_t           in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pwcsb_out_t          out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  pwm_bank_scoreboard  sb;
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  hold_left   = 0;
  logic                sensor_lvl  = 1'b0;

  pwm_channels_with_sensor_block dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Take results, stalling at random or for a requested long stretch
  initial begin : result_side
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Write one register over the configuration port
  task automatic cfg_write(input reg_idx_e idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_cfg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one request, idling first at random, and hold it until taken
  task automatic send_req(input pwcsb_in_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_bank();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic pwcsb_in_t mk_req(logic cmd, logic sensed, int idx, logic [LEN_W-1:0] val);
    pwcsb_in_t req;
    req.cmd        = cmd;
    req.sensor_hit = sensed;
    req.ch_index   = IDX_W'(idx);
    req.value      = val;
    return req;
  endfunction

  // Mostly ticks with runs of sensor level, the rest set requests of mostly short lengths
  function automatic pwcsb_in_t random_request();
    pwcsb_in_t req;
    req.value      = $urandom();
    req.ch_index   = IDX_W'($urandom_range(15));
    req.sensor_hit = 1'($urandom_range(1));
    if ($urandom_range(99) < 70) begin
      req.cmd = CMD_TICK;
      if ($urandom_range(99) < 15) sensor_lvl = ~sensor_lvl;
      req.sensor_hit = sensor_lvl;
    end else begin
      req.cmd = CMD_SET;
      if ($urandom_range(99) < 85) req.ch_index = IDX_W'($urandom_range(11));
      case ($urandom_range(9))
        0: req.value = '0;
        1: req.value = $urandom();
        2: req.value = '1;
        default: req.value = LEN_W'($urandom_range(6));
      endcase
    end
    return req;
  endfunction

  task automatic run_phase(input logic [PIN_W-1:0] mask, input logic [CNT_W-1:0] thr,
                           input logic [CNT_W-1:0] rel, input int tx_pct, input int rx_pct,
                           input int count, input bit with_pressure);
    drain_bank();
    cfg_write(REG_BLOCK_MASK, DATA_W'(mask));
    cfg_write(REG_THRESHOLD, DATA_W'(thr));
    cfg_write(REG_RELEASE, DATA_W'(rel));
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      // Back up the bank with a long receiver hold, later let it empty out
      if (with_pressure && n == count / 3) hold_left = 300;
      if (with_pressure && n == 2 * count / 3) drain_bank();
      send_req(random_request());
    end
  endtask

  initial begin : main_flow
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 18;
    rx_idle_pct = 83;

    // Directed requests: index decoding, ignored fields, entry and release
    cfg_write(REG_BLOCK_MASK, 32'h105);
    cfg_write(REG_THRESHOLD, 32'd2);
    cfg_write(REG_RELEASE, 32'd1);
    send_req(mk_req(CMD_SET, 1'b0, 0, 32'd1));
    send_req(mk_req(CMD_SET, 1'b0, 10, 32'd2));
    send_req(mk_req(CMD_SET, 1'b0, 2, 32'd3));
    send_req(mk_req(CMD_SET, 1'b1, 8, 32'hFFFF_FFFF));
    send_req(mk_req(CMD_SET, 1'b0, 1, 32'd1));
    send_req(mk_req(CMD_SET, 1'b0, 11, 32'd0));
    send_req(mk_req(CMD_SET, 1'b0, 9, 32'd5));
    send_req(mk_req(CMD_SET, 1'b0, 12, 32'd7));
    send_req(mk_req(CMD_SET, 1'b1, 15, 32'hFFFF_FFFF));
    send_req(mk_req(CMD_TICK, 1'b0, 15, 32'hFFFF_FFFF));
    send_req(mk_req(CMD_TICK, 1'b0, 0, 32'd0));
    send_req(mk_req(CMD_TICK, 1'b1, 0, 32'd0));
    send_req(mk_req(CMD_TICK, 1'b1, 0, 32'd0));
    send_req(mk_req(CMD_TICK, 1'b1, 5, 32'h5555_5555));
    send_req(mk_req(CMD_TICK, 1'b0, 0, 32'd0));
    send_req(mk_req(CMD_TICK, 1'b0, 0, 32'd0));
    send_req(mk_req(CMD_SET, 1'b1, 2, 32'd0));
    send_req(mk_req(CMD_SET, 1'b0, 7, 32'd4));
    send_req(mk_req(CMD_TICK, 1'b1, 10, 32'hAAAA_AAAA));
    send_req(mk_req(CMD_TICK, 1'b1, 0, 32'd0));
    send_req(mk_req(CMD_TICK, 1'b0, 0, 32'd0));
    send_req(mk_req(CMD_SET, 1'b0, 3, 32'h8000_0000));
    send_req(mk_req(CMD_TICK, 1'b0, 0, 32'd0));

    // Random phases across settings, extremes included
    run_phase(9'h1FF, 16'd3, 16'd2, 18, 83, 150, 1'b0);
    run_phase(9'h000, 16'd0, 16'd0, 18, 83, 150, 1'b1);
    run_phase(PIN_W'($urandom()), 16'hFFFF, 16'hFFFF, 83, 18, 150, 1'b0);
    run_phase(PIN_W'($urandom()), 16'd1, 16'd1, 83, 18, 150, 1'b0);
    run_phase(9'h155, CNT_W'($urandom_range(1, 6)), CNT_W'($urandom_range(1, 6)),
              0, 0, 150, 1'b0);
    run_phase(9'h003, 16'd5, 16'd4, 0, 0, 150, 1'b1);

    drain_bank();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pwcsb_pkg.sv
rtl/core/pwcsb_regs.sv
rtl/core/pwcsb_dp.sv
rtl/core/pwcsb_ctrl.sv
rtl/core/pwm_channels_with_sensor_block.sv
tb/sv/tb_pwm_channels_with_sensor_block.sv
